// ===== src/sbfr_pkg.sv =====
// Shared constants and types for the SLIP bit-level frame receiver.
`timescale 1ns / 1ps

package sbfr_pkg;

	localparam logic [7:0] SLIP_END  = 8'hC0;
	localparam logic       CMD_SAMPLE = 1'b0;
	localparam logic       CMD_READ   = 1'b1;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [2:0] LAST_BIT      = 3'd7;

	// Per-request status flags carried from the framer to the output stage.
	typedef struct packed {
		logic frame_done;
		logic receiving;
		logic overflow;
		logic frame_ready;
	} status_t;

endpackage

// ===== src/sbfr_store.sv =====
// Ping-pong frame store: one write port and one registered read port.
`timescale 1ns / 1ps

module sbfr_store import sbfr_pkg::*; #(
	parameter int BUFFER_DEPTH = 256,
	parameter int AW = $clog2(2 * BUFFER_DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data_q
);

	logic [7:0] mem [2 * BUFFER_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds while no read is issued, so a stalled result keeps its byte.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

// ===== src/sbfr_framer.sv =====
// Receiver state: delimiter hunt, byte assembly, bank control and store addressing.
`timescale 1ns / 1ps

module sbfr_framer import sbfr_pkg::*; #(
	parameter int BUFFER_DEPTH = 256,
	parameter int AW = $clog2(2 * BUFFER_DEPTH),
	parameter int CW = $clog2(BUFFER_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          command,
	input  logic          rx_level,
	input  logic [7:0]    read_index,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	output logic          rd_hit,
	output status_t       status,
	output logic [8:0]    frame_length
);

	logic [7:0]    window_q, window_d, win;
	logic [3:0]    bit_count_q, bit_count_d;
	logic [CW-1:0] byte_count_q, byte_count_d;
	logic [CW-1:0] done_length_q, done_length_d;
	logic          in_frame_q, in_frame_d;
	logic          bank_q, bank_d;
	logic          done_valid_q, done_valid_d;
	logic          done, ovf;
	logic [CW-1:0] wr_idx;
	logic [AW+CW-1:0] wr_sum;
	logic [AW+7:0]    rd_sum;
	logic [CW+8:0]    len_ext;

	always_comb begin
		window_d      = window_q;
		bit_count_d   = bit_count_q;
		byte_count_d  = byte_count_q;
		done_length_d = done_length_q;
		in_frame_d    = in_frame_q;
		bank_d        = bank_q;
		done_valid_d  = done_valid_q;
		done          = 1'b0;
		ovf           = 1'b0;
		wr_en         = 1'b0;
		wr_idx        = '0;
		wr_data       = SLIP_END;
		win           = '0;

		if (accept && command == CMD_SAMPLE) begin
			if (!in_frame_q) begin
				// The first eight bits of a hunt fill the window in place; later ones shift.
				if (bit_count_q < BITS_PER_BYTE) begin
					win = window_q | (8'(rx_level) << bit_count_q[2:0]);
				end else begin
					win = {rx_level, window_q[7:1]};
				end
				if (win == SLIP_END) begin
					wr_en        = 1'b1;
					in_frame_d   = 1'b1;
					byte_count_d = CW'(1);
					bit_count_d  = '0;
					window_d     = '0;
				end else begin
					window_d = win;
					if (bit_count_q < BITS_PER_BYTE) begin
						bit_count_d = bit_count_q + 4'd1;
					end
				end
			end else begin
				win = window_q | (8'(rx_level) << bit_count_q[2:0]);
				if (bit_count_q[2:0] == LAST_BIT) begin
					bit_count_d = '0;
					if (win == SLIP_END) begin
						wr_en         = 1'b1;
						wr_idx        = byte_count_q;
						done_length_d = byte_count_q + CW'(1);
						done_valid_d  = 1'b1;
						bank_d        = ~bank_q;
						done          = 1'b1;
						in_frame_d    = 1'b0;
						byte_count_d  = '0;
						window_d      = '0;
					end else if ((CW+1)'(byte_count_q) + (CW+1)'(1)
							>= (CW+1)'(BUFFER_DEPTH)) begin
						// Frame would run past its bank: drop it and hunt again.
						ovf          = 1'b1;
						in_frame_d   = 1'b0;
						byte_count_d = '0;
						window_d     = '0;
					end else begin
						wr_en        = 1'b1;
						wr_idx       = byte_count_q;
						wr_data      = win;
						byte_count_d = byte_count_q + CW'(1);
						window_d     = '0;
					end
				end else begin
					bit_count_d = bit_count_q + 4'd1;
					window_d    = win;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q      <= '0;
			bit_count_q   <= '0;
			byte_count_q  <= '0;
			done_length_q <= '0;
			in_frame_q    <= 1'b0;
			bank_q        <= 1'b0;
			done_valid_q  <= 1'b0;
		end else begin
			window_q      <= window_d;
			bit_count_q   <= bit_count_d;
			byte_count_q  <= byte_count_d;
			done_length_q <= done_length_d;
			in_frame_q    <= in_frame_d;
			bank_q        <= bank_d;
			done_valid_q  <= done_valid_d;
		end
	end

	// Writes fill the current bank; reads look at the other, completed one.
	assign wr_sum  = (AW+CW)'(wr_idx) + (bank_q ? (AW+CW)'(BUFFER_DEPTH) : '0);
	assign wr_addr = wr_sum[AW-1:0];

	assign rd_sum  = (AW+8)'(read_index) + (!bank_q ? (AW+8)'(BUFFER_DEPTH) : '0);
	assign rd_addr = rd_sum[AW-1:0];
	assign rd_en   = accept && command == CMD_READ;
	assign rd_hit  = rd_en && done_valid_q && ((CW+8)'(read_index) < (CW+8)'(done_length_q));

	assign status.frame_done  = done;
	assign status.receiving   = in_frame_d;
	assign status.overflow    = ovf;
	assign status.frame_ready = done_valid_d;

	assign len_ext      = (CW+9)'(done_length_d);
	assign frame_length = len_ext[8:0];

endmodule

// ===== src/slip_bit_frame_receiver.sv =====
// Top level of the SLIP bit-level frame receiver with its ping-pong frame store.
//
//  channel  dir  tdata (low bit up)                                   tuser
//  s_       in   rx_level, read_index[7:0], pad to 16                 command
//  m_       out  frame_done, frame_length[8:0], read_data[7:0],       -
//                receiving, overflow, frame_ready, pad to 24
//
// One request is taken every cycle while no result is held or m_tready is high; its
// result appears in the cycle after it is accepted, matching the registered read port
// of the frame store. State updates and store writes happen in the cycle a request is
// accepted. Reset clears all receiver state; the store itself is not cleared. A stalled
// result holds and blocks new requests only while m_tready is low.
`timescale 1ns / 1ps

module slip_bit_frame_receiver import sbfr_pkg::*; #(
	parameter int BUFFER_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // rx_level, read_index[7:0], zero pad
	input  logic [0:0]  s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // frame_done, frame_length[8:0], read_data[7:0],
	                              // receiving, overflow, frame_ready, zero pad
);

	localparam int AW = $clog2(2 * BUFFER_DEPTH);
	localparam int CW = $clog2(BUFFER_DEPTH + 1);

	logic          accept;
	logic          wr_en, rd_en, rd_hit;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, mem_rd_q;
	status_t       status;
	logic [8:0]    frame_length;

	logic          valid_s1;
	status_t       status_s1;
	logic [8:0]    length_s1;
	logic          hit_s1;
	logic [7:0]    read_data;

	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	sbfr_framer #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.AW(AW),
		.CW(CW)
	) u_framer (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.command(s_tuser[0]),
		.rx_level(s_tdata[0]),
		.read_index(s_tdata[8:1]),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_hit(rd_hit),
		.status(status),
		.frame_length(frame_length)
	);

	sbfr_store #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data_q(mem_rd_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
			length_s1 <= frame_length;
			hit_s1    <= rd_hit;
		end
	end

	assign read_data = hit_s1 ? mem_rd_q : 8'd0;
	assign m_tvalid  = valid_s1;
	assign m_tdata   = {3'b000, status_s1.frame_ready, status_s1.overflow,
		status_s1.receiving, read_data, length_s1, status_s1.frame_done};

`ifndef ASSERT_OFF
	// The filling bank and the readable bank never collide in one cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && rd_en |-> wr_addr != rd_addr)
		else $error("store write and read hit the same entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[19]))
		else $error("frame closed and dropped at once");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[20] && !m_tdata[18])
		else $error("closed frame not ready or receiver still in frame");

	// A read that hits returns data only when a frame is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && hit_s1 |-> m_tdata[20])
		else $error("read hit without a completed frame");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the SLIP bit-level frame receiver.
`timescale 1ns / 1ps

module tb_top;
	import sbfr_pkg::*;

	localparam int FRAME_DEPTH = 256;

	typedef struct {
		logic       cmd;
		logic       rx;
		logic [7:0] idx;
		bit         drain;
	} line_req_t;

	typedef struct packed {
		logic       done;
		logic [8:0] len;
		logic [7:0] rdata;
		logic       recv;
		logic       ovf;
		logic       ready;
	} rx_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // rx_level, read_index[7:0], zero pad
	logic [0:0]  s_tuser = '0;   // command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // frame_done, frame_length[8:0], read_data[7:0],
	                             // receiving, overflow, frame_ready, zero pad

	slip_bit_frame_receiver #(.BUFFER_DEPTH(FRAME_DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	line_req_t  line_requests[$];
	rx_status_t expected_status[$];
	int         requests_sent = 0;
	int         results_seen = 0;
	int         mismatch_count = 0;
	int         send_gap = 0;
	int         ready_hold = 0;
	bit         send_steady = 0;
	bit         sink_steady = 0;
	int         last_frame_len = 0;

	// Receiver state as the testbench sees it.
	logic [7:0] hunt_window = '0;
	logic [3:0] bits_taken = '0;
	logic [8:0] bytes_stored = '0;
	logic       in_frame = 1'b0;
	logic       fill_bank = 1'b0;
	logic [8:0] held_length = '0;
	logic       held_valid = 1'b0;
	logic [7:0] frame_bytes [0:2*FRAME_DEPTH-1];

	function automatic void restart_hunt();
		in_frame = 1'b0;
		bytes_stored = '0;
		bits_taken = '0;
		hunt_window = '0;
	endfunction

	function automatic rx_status_t advance_receiver(logic cmd, logic rx, logic [7:0] idx);
		rx_status_t r;
		r = '0;
		if (cmd == CMD_READ) begin
			if (held_valid && {1'b0, idx} < held_length)
				r.rdata = frame_bytes[{~fill_bank, idx}];
		end else if (!in_frame) begin
			// The first byte after a restart fills the window in place; then it slides.
			if (bits_taken < BITS_PER_BYTE)
				hunt_window[bits_taken[2:0]] = rx;
			else
				hunt_window = {rx, hunt_window[7:1]};
			if (hunt_window == SLIP_END) begin
				frame_bytes[{fill_bank, 8'd0}] = SLIP_END;
				in_frame = 1'b1;
				bytes_stored = 9'd1;
				bits_taken = '0;
				hunt_window = '0;
			end else if (bits_taken < BITS_PER_BYTE) begin
				bits_taken++;
			end
		end else begin
			hunt_window[bits_taken[2:0]] = rx;
			bits_taken++;
			if (bits_taken >= BITS_PER_BYTE) begin
				bits_taken = '0;
				if (hunt_window == SLIP_END) begin
					frame_bytes[{fill_bank, bytes_stored[7:0]}] = SLIP_END;
					held_length = bytes_stored + 9'd1;
					held_valid = 1'b1;
					fill_bank = ~fill_bank;
					r.done = 1'b1;
					restart_hunt();
				end else if (int'(bytes_stored) + 1 >= FRAME_DEPTH) begin
					r.ovf = 1'b1;
					restart_hunt();
				end else begin
					frame_bytes[{fill_bank, bytes_stored[7:0]}] = hunt_window;
					bytes_stored++;
					hunt_window = '0;
				end
			end
		end
		r.len = held_valid ? held_length : 9'd0;
		r.recv = in_frame;
		r.ready = held_valid;
		return r;
	endfunction

	function automatic int draw_gap(bit steady);
		return steady ? 0 : int'($urandom_range(0, 4));
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
	endtask

	task automatic queue_req(logic cmd, logic rx, logic [7:0] idx, bit drain = 0);
		line_req_t q;
		q.cmd = cmd;
		q.rx = rx;
		q.idx = idx;
		q.drain = drain;
		line_requests.push_back(q);
	endtask

	task automatic queue_read(int idx);
		queue_req(CMD_READ, 1'($urandom), 8'(idx));
	endtask

	// Line bits go out least significant first; read_index is don't-care here.
	task automatic queue_byte(logic [7:0] b);
		for (int i = 0; i < 8; i++)
			queue_req(CMD_SAMPLE, b[i], 8'($urandom));
	endtask

	task automatic queue_noise(int n);
		repeat (n) queue_req(CMD_SAMPLE, 1'($urandom), 8'($urandom));
	endtask

	function automatic logic [7:0] data_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == SLIP_END);
		return b;
	endfunction

	task automatic queue_frame(int n, bit with_reads);
		queue_byte(SLIP_END);
		repeat (n) begin
			queue_byte(data_byte());
			if (with_reads && $urandom_range(0, 5) == 0)
				queue_read($urandom_range(0, 255));
		end
		queue_byte(SLIP_END);
		last_frame_len = n + 2;
	endtask

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_status.push_back(advance_receiver(s_tuser[0], s_tdata[0],
					s_tdata[8:1]));
				requests_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if ($urandom_range(0, 63) == 0)
					send_steady = !send_steady;
				if (send_gap != 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (line_requests.size() != 0 &&
						!(line_requests[0].drain && requests_sent != results_seen)) begin
					s_tvalid <= 1'b1;
					s_tdata <= {7'b0, line_requests[0].idx, line_requests[0].rx};
					s_tuser <= line_requests[0].cmd;
					void'(line_requests.pop_front());
					send_gap = draw_gap(send_steady);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_status.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result 0x%06h arrived with nothing expected",
							$realtime, m_tdata);
				end else begin
					rx_status_t want;
					want = expected_status.pop_front();
					if (m_tdata[0] !== want.done)
						report_mismatch("frame_done", want.done, m_tdata[0]);
					if (m_tdata[9:1] !== want.len)
						report_mismatch("frame_length", want.len, m_tdata[9:1]);
					if (m_tdata[17:10] !== want.rdata)
						report_mismatch("read_data", want.rdata, m_tdata[17:10]);
					if (m_tdata[18] !== want.recv)
						report_mismatch("receiving", want.recv, m_tdata[18]);
					if (m_tdata[19] !== want.ovf)
						report_mismatch("overflow", want.ovf, m_tdata[19]);
					if (m_tdata[20] !== want.ready)
						report_mismatch("frame_ready", want.ready, m_tdata[20]);
				end
				if ($urandom_range(0, 63) == 0)
					sink_steady = !sink_steady;
				ready_hold = draw_gap(sink_steady);
			end else if (ready_hold != 0) begin
				ready_hold--;
			end
			m_tready <= (ready_hold == 0);
		end
	end

	initial begin
		int random_start;
		int pick;

		// Reads with no frame held, then an opening delimiter preceded by stray bits.
		queue_read(0);
		queue_read(255);
		queue_req(CMD_SAMPLE, 1'b1, 8'h00);
		queue_req(CMD_SAMPLE, 1'b0, 8'hFF);
		queue_req(CMD_SAMPLE, 1'b1, 8'h00);
		queue_byte(SLIP_END);
		// Empty frame: two delimiters back to back.
		queue_byte(SLIP_END);
		queue_read(0);
		queue_read(1);
		queue_read(2);
		// Frame with extreme data values and a read while it is being received.
		queue_byte(SLIP_END);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_read(1);
		queue_byte(8'h7F);
		queue_byte(8'h80);
		queue_byte(SLIP_END);
		for (int i = 0; i < 7; i++)
			queue_read(i);
		// Longest frame the store takes, then one that overflows it.
		queue_frame(FRAME_DEPTH - 2, 1'b0);
		queue_read(255);
		queue_read(0);
		queue_byte(SLIP_END);
		repeat (FRAME_DEPTH - 1) queue_byte(data_byte());
		queue_read(255);
		queue_frame(1, 1'b0);
		queue_read(1);

		// Random traffic, mostly well-formed frames; wait for the pipe to empty first.
		queue_req(CMD_SAMPLE, 1'b0, 8'h00, 1'b1);
		random_start = line_requests.size();
		while (line_requests.size() - random_start < 1400) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				queue_noise($urandom_range(0, 6));
				queue_frame($urandom_range(0, 3) == 0 ? $urandom_range(0, 40) :
					$urandom_range(0, 6), 1'b1);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1) == 0)
						queue_read($urandom_range(0, last_frame_len > 254 ? 255 :
							last_frame_len + 1));
					else
						queue_read($urandom_range(0, 255));
				end
			end else if (pick < 95) begin
				queue_noise($urandom_range(1, 20));
			end else begin
				// Broken frame: opened, a few bytes, then cut off by noise.
				queue_byte(SLIP_END);
				repeat ($urandom_range(0, 3)) queue_byte(8'($urandom));
				queue_noise($urandom_range(1, 12));
			end
			if ($urandom_range(0, 40) == 0)
				queue_req(CMD_READ, 1'b0, 8'($urandom), 1'b1);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (line_requests.size() != 0 || s_tvalid || requests_sent != results_seen)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_status.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/sbfr_pkg.sv
src/sbfr_store.sv
src/sbfr_framer.sv
src/slip_bit_frame_receiver.sv
verif/tb_top.sv
